// ===== rtl/core/eppi_pkg.sv =====
package eppi_pkg;

    localparam int NOTE_CNT = 129;
    localparam int NOTE_HZ_W = 14;
    // widest table entry over the supported sample rates: 13289 * 2^32 / 8000 < 2^33
    localparam int STEP_W = 33;
    localparam int FRAC_W = 24;
    localparam int MAG_W = 31;
    localparam int IDX_W = 7;

    typedef logic [NOTE_CNT-1:0][STEP_W-1:0] t_step_tab;

    // floor of note frequency in hz, notes 0..128
    localparam logic [NOTE_HZ_W-1:0] NOTE_HZ [0:NOTE_CNT-1] = '{
        14'd8, 14'd8, 14'd9, 14'd9, 14'd10, 14'd10, 14'd11, 14'd12, 14'd12, 14'd13,
        14'd14, 14'd15, 14'd16, 14'd17, 14'd18, 14'd19, 14'd20, 14'd21, 14'd23, 14'd24,
        14'd25, 14'd27, 14'd29, 14'd30, 14'd32, 14'd34, 14'd36, 14'd38, 14'd41, 14'd43,
        14'd46, 14'd48, 14'd51, 14'd55, 14'd58, 14'd61, 14'd65, 14'd69, 14'd73, 14'd77,
        14'd82, 14'd87, 14'd92, 14'd97, 14'd103, 14'd110, 14'd116, 14'd123, 14'd130,
        14'd138, 14'd146, 14'd155, 14'd164, 14'd174, 14'd184, 14'd195, 14'd207, 14'd220,
        14'd233, 14'd246, 14'd261, 14'd277, 14'd293, 14'd311, 14'd329, 14'd349, 14'd369,
        14'd391, 14'd415, 14'd440, 14'd466, 14'd493, 14'd523, 14'd554, 14'd587, 14'd622,
        14'd659, 14'd698, 14'd739, 14'd783, 14'd830, 14'd880, 14'd932, 14'd987,
        14'd1046, 14'd1108, 14'd1174, 14'd1244, 14'd1318, 14'd1396, 14'd1479, 14'd1567,
        14'd1661, 14'd1760, 14'd1864, 14'd1975, 14'd2093, 14'd2217, 14'd2349, 14'd2489,
        14'd2637, 14'd2793, 14'd2959, 14'd3135, 14'd3322, 14'd3520, 14'd3729, 14'd3951,
        14'd4186, 14'd4434, 14'd4698, 14'd4978, 14'd5274, 14'd5587, 14'd5919, 14'd6271,
        14'd6644, 14'd7040, 14'd7458, 14'd7902, 14'd8372, 14'd8869, 14'd9397, 14'd9956,
        14'd10548, 14'd11175, 14'd11839, 14'd12543, 14'd13289
    };

endpackage

// ===== rtl/core/exp_pitch_to_phase_increment.sv =====
// Exponential pitch to phase increment converter. Each request carries a signed pitch
// word (2^24 per semitone), an fm source and an fm depth; the high half of source times
// depth is added to the pitch, the magnitude saturates to 2^31-1, its top 7 bits pick an
// entry of a 129-entry exponential frequency table built at elaboration for
// AUDIO_RATE_HZ, and the low 24 bits interpolate linearly to the next entry. The sign is
// put back on the result, and m_axis_tuser flags a negative pitch. The pipeline has five
// register stages (fm multiply, sum and saturate, table lookup, interpolation multiply,
// add and sign), and one request is taken every cycle unless the output stalls. Each stage
// holds its own valid bit and fills when empty, so bubbles close up under back-pressure;
// s_axis_tready follows m_axis_tready combinationally through those valid bits.
module exp_pitch_to_phase_increment #(
    parameter int AUDIO_RATE_HZ = 44100
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [95:0] s_axis_tdata,   // pitch_word, fm_source, fm_amount
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // phase_increment
    output logic [0:0]  m_axis_tuser    // went_negative
);

    localparam int STEP_W = eppi_pkg::STEP_W;
    localparam int FRAC_W = eppi_pkg::FRAC_W;
    localparam int MAG_W = eppi_pkg::MAG_W;
    localparam int IDX_W = eppi_pkg::IDX_W;
    localparam int NUM_W = eppi_pkg::NOTE_HZ_W + 32;
    localparam int PROD_W = FRAC_W + STEP_W;

    function automatic eppi_pkg::t_step_tab build_tab();
        eppi_pkg::t_step_tab tab;
        logic [NUM_W-1:0]    num;
        for (int i = 0; i < eppi_pkg::NOTE_CNT; i++) begin
            num = {eppi_pkg::NOTE_HZ[i], 32'd0};
            tab[i] = STEP_W'(num / NUM_W'(AUDIO_RATE_HZ));
        end
        return tab;
    endfunction

    localparam eppi_pkg::t_step_tab STEP_TAB = build_tab();

    // per stage valid and load enable, stage 4 is the output register
    logic [4:0] r_vld;
    logic [4:0] rdy;

    assign rdy[4] = !r_vld[4] || m_axis_tready;
    assign rdy[3] = !r_vld[3] || rdy[4];
    assign rdy[2] = !r_vld[2] || rdy[3];
    assign rdy[1] = !r_vld[1] || rdy[2];
    assign rdy[0] = !r_vld[0] || rdy[1];
    assign s_axis_tready = rdy[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (rdy[0]) r_vld[0] <= s_axis_tvalid;
            if (rdy[1]) r_vld[1] <= r_vld[0];
            if (rdy[2]) r_vld[2] <= r_vld[1];
            if (rdy[3]) r_vld[3] <= r_vld[2];
            if (rdy[4]) r_vld[4] <= r_vld[3];
        end
    end

    // stage 0: fm product
    logic signed [63:0] r_fm_prod;
    logic signed [31:0] r_pitch0;
    logic signed [63:0] n_fm_prod;

    assign n_fm_prod = $signed(s_axis_tdata[63:32]) * $signed(s_axis_tdata[95:64]);

    always_ff @(posedge i_clk) begin
        if (rdy[0]) begin
            r_fm_prod <= n_fm_prod;
            r_pitch0  <= $signed(s_axis_tdata[31:0]);
        end
    end

    // stage 1: sum, sign split and magnitude saturation
    logic signed [32:0] sum;
    logic [32:0]        abs_sum;
    logic [MAG_W-1:0]   n_mag;
    logic [MAG_W-1:0]   r_mag;
    logic               r_neg1;

    assign sum     = {r_pitch0[31], r_pitch0} + {r_fm_prod[63], r_fm_prod[63:32]};
    assign abs_sum = sum[32] ? 33'(-sum) : 33'(sum);
    assign n_mag   = (abs_sum[32:MAG_W] != '0) ? {MAG_W{1'b1}} : abs_sum[MAG_W-1:0];

    always_ff @(posedge i_clk) begin
        if (rdy[1]) begin
            r_mag  <= n_mag;
            r_neg1 <= sum[32];
        end
    end

    // stage 2: table lookup of both neighbors
    logic [IDX_W:0]    idx0;
    logic [IDX_W:0]    idx1;
    logic [STEP_W-1:0] f0;
    logic [STEP_W-1:0] f1;
    logic [STEP_W-1:0] r_f0_2;
    logic [STEP_W-1:0] r_diff;
    logic [FRAC_W-1:0] r_frac;
    logic              r_neg2;

    assign idx0 = {1'b0, r_mag[MAG_W-1:FRAC_W]};
    assign idx1 = idx0 + 1'b1;
    assign f0   = STEP_TAB[idx0];
    assign f1   = STEP_TAB[idx1];

    always_ff @(posedge i_clk) begin
        if (rdy[2]) begin
            r_f0_2 <= f0;
            r_diff <= f1 - f0;
            r_frac <= r_mag[FRAC_W-1:0];
            r_neg2 <= r_neg1;
        end
    end

    // stage 3: interpolation product
    logic [PROD_W-1:0] r_ip_prod;
    logic [STEP_W-1:0] r_f0_3;
    logic              r_neg3;

    always_ff @(posedge i_clk) begin
        if (rdy[3]) begin
            r_ip_prod <= PROD_W'(r_frac) * PROD_W'(r_diff);
            r_f0_3    <= r_f0_2;
            r_neg3    <= r_neg2;
        end
    end

    // stage 4: add, saturate, put sign back
    logic [STEP_W:0]  inc;
    logic [MAG_W-1:0] inc_sat;
    logic [31:0]      n_phase;
    logic [31:0]      r_phase;
    logic             r_neg4;

    assign inc     = {1'b0, r_f0_3} + {1'b0, r_ip_prod[PROD_W-1:FRAC_W]};
    assign inc_sat = (inc[STEP_W:MAG_W] != '0) ? {MAG_W{1'b1}} : inc[MAG_W-1:0];
    assign n_phase = r_neg3 ? (32'd0 - {1'b0, inc_sat}) : {1'b0, inc_sat};

    always_ff @(posedge i_clk) begin
        if (rdy[4]) begin
            r_phase <= n_phase;
            r_neg4  <= r_neg3;
        end
    end

    assign m_axis_tvalid   = r_vld[4];
    assign m_axis_tdata    = r_phase;
    assign m_axis_tuser[0] = r_neg4;

`ifndef SYNTHESIS
    // every table entry is positive, so the sign bit follows the flag
    a_sign_matches_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[31] == m_axis_tuser[0]))
        else $error("phase sign disagrees with went_negative");

    a_no_min_int: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata != 32'h8000_0000))
        else $error("phase increment outside symmetric range");

    a_ready_when_out_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled although output stage is empty");

    a_held_stage_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[3] && !rdy[3]) |=> r_vld[3])
        else $error("stalled interpolation stage dropped its request");
`endif

endmodule
